// ===== rtl/core/mtfm_pkg.sv =====
// Shared types, codes and constants for the MQTT topic filter matcher.
package mtfm_pkg;

   // Field widths of the request and response beats
   localparam int MODE_W = 2;
   localparam int SLOT_W = 3;
   localparam int POS_W  = 6;
   localparam int BYTE_W = 8;
   localparam int MASK_W = 8;

   // Default sizing
   localparam int DEF_NUM_FILTERS    = 8;
   localparam int DEF_MAX_FILTER_LEN = 64;

   // Bytes that steer the matching
   localparam logic [BYTE_W-1:0] CHAR_SLASH  = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_PLUS   = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_HASH   = 8'h23;

   // Request opcodes
   typedef enum logic [MODE_W-1:0] {
      MODE_WRITE = 2'd0,
      MODE_TOPIC = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   // Per-lane match status
   typedef enum logic [2:0] {
      ST_START = 3'd0,
      ST_LIT   = 3'd1,
      ST_PLUS  = 3'd2,
      ST_ALL   = 3'd3,
      ST_FAIL  = 3'd4
   } lane_status_type;

   // Command broadcast from the top level to every lane for one accepted beat
   typedef struct packed {
      logic              topic;     // topic byte accepted
      logic              at_start;  // no topic in progress
      logic              write;     // filter byte accepted, position in range
      logic              clear;     // slot clear accepted
      logic              last;
      logic [POS_W-1:0]  position;
      logic [BYTE_W-1:0] data_byte;
   } lane_cmd_type;

endpackage

// ===== rtl/core/mtfm_byte_mem.sv =====
// Byte-wide filter memory: one write port, one registered read port, write-first.
module mtfm_byte_mem #(
   parameter int ADDR_W = 6
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [mtfm_pkg::BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [mtfm_pkg::BYTE_W-1:0] rd_data
);
   import mtfm_pkg::*;

   localparam int DEPTH = 1 << ADDR_W;

   logic [BYTE_W-1:0] mem_ff [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // Storage write and registered read, a same-address write is forwarded
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_data;
      end else begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mtfm_lane.sv =====
// One filter lane: filter storage, cursor, status, per-byte step and end-of-topic verdict.
module mtfm_lane #(
   parameter int MAX_FILTER_LEN = mtfm_pkg::DEF_MAX_FILTER_LEN
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mtfm_pkg::lane_cmd_type cmd,
   input  logic                  sel,
   output logic                  match
);
   import mtfm_pkg::*;

   localparam int LEN_W  = $clog2(MAX_FILTER_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_FILTER_LEN);
   localparam int SUM_W  = LEN_W + 2;
   localparam int WIN    = 3;

   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  cur_ff;
   lane_status_type   st_ff;
   logic [BYTE_W-1:0] head_ff [WIN];

   logic [BYTE_W-1:0] win_byte [WIN];
   logic [BYTE_W-1:0] step_byte [WIN];
   logic [LEN_W-1:0]  rd_base;
   logic [LEN_W-1:0]  cur_step;
   lane_status_type   st_step;
   logic              wr_hit;
   logic              clr_hit;

   assign wr_hit  = cmd.write && sel;
   assign clr_hit = cmd.clear && sel;

   // Three copies of the filter give the window at cursor, cursor+1, cursor+2
   assign rd_base = cmd.topic ? cur_step : cur_ff;

   for (genvar k = 0; k < WIN; k++) begin : g_copy
      logic [SUM_W-1:0] rd_sum;
      assign rd_sum = SUM_W'(rd_base) + SUM_W'(k);
      mtfm_byte_mem #(.ADDR_W(ADDR_W)) u_mem (
         .clock   (clock),
         .wr_en   (wr_hit),
         .wr_addr (ADDR_W'(cmd.position)),
         .wr_data (cmd.data_byte),
         .rd_addr (rd_sum[ADDR_W-1:0]),
         .rd_data (win_byte[k])
      );
   end

   // First topic byte reads the filter head from flops, later bytes the window
   always_comb begin
      for (int k = 0; k < WIN; k++) begin
         step_byte[k] = cmd.at_start ? head_ff[k] : win_byte[k];
      end
   end

   // One topic byte against this filter
   always_comb begin
      logic [SUM_W-1:0] cx;
      logic [SUM_W-1:0] cy;
      logic [SUM_W-1:0] cz;
      logic [SUM_W-1:0] nx;
      logic             end1;
      logic             lvl_hash;
      logic             lvl_plus;
      logic             adv;
      logic [BYTE_W-1:0] cb;
      lane_status_type  s0;
      lane_status_type  sa;

      cx = cmd.at_start ? '0 : SUM_W'(cur_ff);
      nx = SUM_W'(len_ff);
      if (cmd.at_start) begin
         s0 = (len_ff == '0) ? ST_FAIL : ST_START;
      end else begin
         s0 = st_ff;
      end
      end1     = (cx + SUM_W'(1)) == nx;
      lvl_hash = (cx < nx) && (step_byte[0] == CHAR_HASH) &&
                 (end1 || (step_byte[1] == CHAR_SLASH));
      lvl_plus = (cx < nx) && (step_byte[0] == CHAR_PLUS) &&
                 (end1 || (step_byte[1] == CHAR_SLASH));

      // level start: decide wildcard or literal
      adv = 1'b0;
      sa  = s0;
      if (s0 == ST_START) begin
         if (cmd.at_start && (cmd.data_byte == CHAR_DOLLAR) && (lvl_hash || lvl_plus)) begin
            sa = ST_FAIL;
         end else if (lvl_hash) begin
            sa = end1 ? ST_ALL : ST_FAIL;
         end else if (lvl_plus) begin
            sa  = ST_PLUS;
            adv = 1'b1;
         end else begin
            sa = ST_LIT;
         end
      end

      cy = cx + SUM_W'(adv);
      cb = adv ? step_byte[1] : step_byte[0];
      cz = cy;
      st_step = sa;

      // consume the byte
      case (sa)
         ST_PLUS: begin
            if (cmd.data_byte == CHAR_SLASH) begin
               if ((cy < nx) && (cb == CHAR_SLASH)) begin
                  cz      = cy + SUM_W'(1);
                  st_step = ST_START;
               end else begin
                  st_step = ST_FAIL;
               end
            end
         end
         ST_LIT: begin
            if (cmd.data_byte == CHAR_SLASH) begin
               if ((cy < nx) && (cb == CHAR_SLASH)) begin
                  cz      = cy + SUM_W'(1);
                  st_step = ST_START;
               end else begin
                  st_step = ST_FAIL;
               end
            end else if ((cy < nx) && (cb == cmd.data_byte)) begin
               cz = cy + SUM_W'(1);
            end else begin
               st_step = ST_FAIL;
            end
         end
         default: begin
         end
      endcase
      cur_step = cz[LEN_W-1:0];
   end

   // Lane state: filter loads and clears, topic steps
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         cur_ff <= '0;
         st_ff  <= ST_START;
      end else if (wr_hit || clr_hit) begin
         if (wr_hit && cmd.last) begin
            len_ff <= LEN_W'(cmd.position) + LEN_W'(1);
         end else begin
            len_ff <= '0;
         end
         if (!cmd.at_start) begin
            st_ff <= ST_FAIL;
         end
      end else if (cmd.topic) begin
         cur_ff <= cur_step;
         st_ff  <= st_step;
      end
   end

   // Head copy of the first filter bytes
   always_ff @(posedge clock) begin
      for (int k = 0; k < WIN; k++) begin
         if (wr_hit && (32'(cmd.position) == k)) begin
            head_ff[k] <= cmd.data_byte;
         end
      end
   end

   // Verdict at end of topic, from the settled cursor and its window
   always_comb begin
      logic [SUM_W-1:0] fc;
      logic [SUM_W-1:0] nx;
      logic             ends_c;
      logic             ends_c1;
      logic             lvl_h;
      logic             lvl_p;
      logic             hit;

      fc = SUM_W'(cur_ff);
      nx = SUM_W'(len_ff);
      ends_c  = (fc == nx) ||
                (((fc + SUM_W'(2)) == nx) && (win_byte[0] == CHAR_SLASH) &&
                 (win_byte[1] == CHAR_HASH));
      ends_c1 = ((fc + SUM_W'(1)) == nx) ||
                (((fc + SUM_W'(3)) == nx) && (win_byte[1] == CHAR_SLASH) &&
                 (win_byte[2] == CHAR_HASH));
      lvl_h = (fc < nx) && (win_byte[0] == CHAR_HASH) &&
              (((fc + SUM_W'(1)) == nx) || (win_byte[1] == CHAR_SLASH));
      lvl_p = (fc < nx) && (win_byte[0] == CHAR_PLUS) &&
              (((fc + SUM_W'(1)) == nx) || (win_byte[1] == CHAR_SLASH));

      case (st_ff)
         ST_ALL:   hit = 1'b1;
         ST_LIT:   hit = ends_c;
         ST_PLUS:  hit = ends_c;
         ST_START: begin
            if (lvl_h) begin
               hit = (fc + SUM_W'(1)) == nx;
            end else if (lvl_p) begin
               hit = ends_c1;
            end else begin
               hit = ends_c;
            end
         end
         default:  hit = 1'b0;
      endcase
      match = (len_ff != '0) && hit;
   end

endmodule

// ===== rtl/core/mqtt_topic_filter_matcher_unit.sv =====
// A topic's last beat registers a pending verdict in fin_ff, then the response registers.
// One request beat per cycle while req_ready is high; each lane steps once per topic byte.
// A pending end-of-topic verdict stalls intake only while the response is held.
// Reset clears handshake state and disables every filter slot; filter bytes are not cleared
// and need no clearing pass.
module mqtt_topic_filter_matcher_unit #(
   parameter int NUM_FILTERS    = mtfm_pkg::DEF_NUM_FILTERS,
   parameter int MAX_FILTER_LEN = mtfm_pkg::DEF_MAX_FILTER_LEN
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [mtfm_pkg::MODE_W-1:0] req_mode,
   input  logic [mtfm_pkg::SLOT_W-1:0] req_slot,
   input  logic [mtfm_pkg::POS_W-1:0]  req_position,
   input  logic [mtfm_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                        req_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_match_any,
   output logic [mtfm_pkg::MASK_W-1:0] rsp_match_mask
);
   import mtfm_pkg::*;

   logic               start_ff;
   logic               start_in;
   logic               fin_ff;
   logic               fin_in;
   logic               fin_go;
   logic               accept;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               rsp_any_ff;
   logic [MASK_W-1:0]  rsp_mask_ff;
   logic [MASK_W-1:0]  mask_now;
   logic [NUM_FILTERS-1:0] match_vec;
   lane_cmd_type       cmd;

   // Handshake: intake waits only while a verdict cannot move to the response register
   assign fin_go    = fin_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !fin_ff || fin_go;
   assign accept    = req_valid && req_ready;

   // Broadcast command for the accepted beat
   always_comb begin
      cmd.topic     = accept && (req_mode == MODE_TOPIC);
      cmd.at_start  = start_ff;
      cmd.write     = accept && (req_mode == MODE_WRITE) &&
                      (32'(req_position) < MAX_FILTER_LEN);
      cmd.clear     = accept && (req_mode == MODE_CLEAR);
      cmd.last      = req_last;
      cmd.position  = req_position;
      cmd.data_byte = req_data_byte;
   end

   // Filter lanes
   for (genvar i = 0; i < NUM_FILTERS; i++) begin : g_lane
      logic sel;
      assign sel = (32'(req_slot) == i);
      mtfm_lane #(.MAX_FILTER_LEN(MAX_FILTER_LEN)) u_lane (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .sel   (sel),
         .match (match_vec[i])
      );
   end

   // Mask shows the low slots only
   for (genvar j = 0; j < MASK_W; j++) begin : g_mask
      if (j < NUM_FILTERS) begin : g_on
         assign mask_now[j] = match_vec[j];
      end else begin : g_off
         assign mask_now[j] = 1'b0;
      end
   end

   // Topic framing and verdict/response control
   always_comb begin
      start_in = start_ff;
      if (cmd.topic) begin
         start_in = req_last;
      end
      fin_in = fin_go ? 1'b0 : fin_ff;
      if (cmd.topic && req_last) begin
         fin_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fin_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff     <= 1'b1;
         fin_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff     <= start_in;
         fin_ff       <= fin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_any_ff  <= |match_vec;
         rsp_mask_ff <= mask_now;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_match_any  = rsp_any_ff;
   assign rsp_match_mask = rsp_mask_ff;

   // A response beat only ever follows a pending verdict
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(fin_ff))
      else $error("response without a pending verdict");

   // The last topic beat always opens a verdict cycle
   assert property (@(posedge clock) disable iff (reset)
      (cmd.topic && req_last) |=> fin_ff)
      else $error("last topic beat did not raise the verdict");

   // Any set mask bit implies a match overall
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_mask_ff != '0)) |-> rsp_any_ff)
      else $error("mask bit set without match_any");

   // A verdict held back by the response keeps the topic framing closed
   assert property (@(posedge clock) disable iff (reset)
      (fin_ff && !fin_go) |=> (fin_ff && start_ff))
      else $error("stalled verdict lost");

endmodule
